[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg)

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg)

`endif

`endif

[rtl/i2cbm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cbm_pkg
// Types, codes and constants shared by the I2C bit-level master.
// ---------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_DELAY   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRETCH_LIMIT = 8'd1;

  localparam logic [15:0] PHASE_DELAY_RST   = 16'd16;
  localparam logic [15:0] STRETCH_LIMIT_RST = 16'd255;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE  = 3'd1;
  localparam logic [2:0] PH_POLL = 3'd2;
  localparam logic [2:0] PH_POST = 3'd3;
  localparam logic [2:0] PH_HOLD = 3'd4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [3:0] NBITS   = 4'd8;
  localparam int         MSB_POS = 7;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  cmd;
    logic        to_flag;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] delay_count;
    logic [15:0] stretch_count;
    logic        scl_drive;
    logic        sda_drive;
    logic        saved_ack;
  } state_t;

  typedef struct packed {
    logic       done;
    logic       ack;
    logic [7:0] rx;
    logic       to;
  } res_t;

endpackage

[rtl/i2cbm_step.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2cbm_step
// One tick of the bus sequencer: next state and finish result.
// ---------------------------------------------------------------------------
module i2cbm_step import i2cbm_pkg::*; (
  input  state_t      st,
  input  logic [15:0] phase_delay,
  input  logic [15:0] stretch_limit,
  input  logic [2:0]  kind,
  input  logic [7:0]  tx_byte,
  input  logic        ack_to_send,
  input  logic        scl_in,
  input  logic        sda_in,
  output state_t      st_next,
  output res_t        res
);

  typedef struct packed {
    state_t s;
    res_t   r;
  } step_t;

  function automatic step_t fin(step_t x, logic ack, logic [7:0] rx, logic to);
    step_t y;
    y = x;
    y.s.phase = PH_IDLE;
    y.s.cmd   = CMD_NONE;
    y.r.done  = 1'b1;
    y.r.ack   = ack;
    y.r.rx    = rx;
    y.r.to    = to;
    return y;
  endfunction

  // action once a clock-high phase is over
  function automatic step_t high_done(step_t x, logic sda);
    step_t y;
    logic [3:0] bc;
    logic [7:0] sh;
    y = x;
    bc = x.s.bit_count + 4'd1;
    case (x.s.cmd)
      CMD_START: begin
        y.s.sda_drive   = 1'b1;
        y.s.phase       = PH_HOLD;
        y.s.delay_count = '0;
      end
      CMD_STOP: begin
        y.s.sda_drive   = 1'b0;
        y.s.phase       = PH_HOLD;
        y.s.delay_count = '0;
      end
      CMD_WRITE: begin
        y.s.scl_drive = 1'b1;
        if (x.s.bit_count < NBITS) begin
          sh = {x.s.shift_reg[6:0], 1'b0};
          y.s.shift_reg = sh;
          y.s.bit_count = bc;
          y.s.sda_drive = (bc < NBITS) ? ~sh[MSB_POS] : 1'b0;
        end else begin
          y.s.saved_ack = sda;
          y.s.phase     = PH_HOLD;
        end
        if (x.s.bit_count < NBITS) y.s.phase = PH_PRE;
        y.s.delay_count = '0;
      end
      CMD_READ: begin
        y.s.scl_drive = 1'b1;
        if (x.s.bit_count < NBITS) begin
          y.s.shift_reg = {x.s.shift_reg[6:0], sda};
          y.s.bit_count = bc;
          if (bc >= NBITS) y.s.sda_drive = ~x.s.saved_ack;
          y.s.phase = PH_PRE;
        end else begin
          y.s.phase = PH_HOLD;
        end
        y.s.delay_count = '0;
      end
      default: begin
        y = fin(x, 1'b0, 8'd0, 1'b0);
      end
    endcase
    return y;
  endfunction

  step_t cur;
  step_t nxt;
  logic [15:0] dly_inc;
  logic [15:0] str_inc;

  assign dly_inc = (st.delay_count == COUNT_MAX) ? st.delay_count : st.delay_count + 16'd1;
  assign str_inc = (st.stretch_count == COUNT_MAX) ? st.stretch_count
                                                   : st.stretch_count + 16'd1;

  always_comb begin
    cur.s = st;
    cur.r = '0;
    nxt   = cur;
    case (st.phase)
      PH_IDLE: begin
        if (kind inside {[CMD_START:CMD_READ]}) begin
          nxt.s.cmd           = kind;
          nxt.s.to_flag       = 1'b0;
          nxt.s.bit_count     = '0;
          nxt.s.stretch_count = '0;
          case (kind)
            CMD_START: nxt.s.sda_drive = 1'b0;
            CMD_STOP:  nxt.s.sda_drive = 1'b1;
            CMD_WRITE: begin
              nxt.s.shift_reg = tx_byte;
              nxt.s.sda_drive = ~tx_byte[MSB_POS];
            end
            default: begin
              nxt.s.shift_reg = '0;
              nxt.s.saved_ack = ack_to_send;
              nxt.s.sda_drive = 1'b0;
            end
          endcase
          nxt.s.phase       = PH_PRE;
          nxt.s.delay_count = '0;
        end
      end
      PH_PRE: begin
        nxt.s.delay_count = dly_inc;
        if (dly_inc >= phase_delay) begin
          nxt.s.scl_drive     = 1'b0;
          nxt.s.stretch_count = '0;
          nxt.s.phase         = PH_POLL;
        end
      end
      PH_POLL: begin
        if (scl_in) begin
          nxt.s.phase       = PH_POST;
          nxt.s.delay_count = '0;
        end else begin
          nxt.s.stretch_count = str_inc;
          if (str_inc >= stretch_limit) begin
            if (st.cmd == CMD_WRITE) begin
              nxt = fin(nxt, 1'b1, 8'd0, 1'b1);
            end else if (st.cmd == CMD_READ) begin
              nxt = fin(nxt, 1'b0, 8'd0, 1'b1);
            end else begin
              nxt.s.to_flag = 1'b1;
              nxt = high_done(nxt, sda_in);
            end
          end
        end
      end
      PH_POST: begin
        nxt.s.delay_count = dly_inc;
        if (dly_inc >= phase_delay) nxt = high_done(nxt, sda_in);
      end
      PH_HOLD: begin
        nxt.s.delay_count = dly_inc;
        if (dly_inc >= phase_delay) begin
          case (st.cmd)
            CMD_START: begin
              nxt.s.scl_drive = 1'b1;
              nxt = fin(nxt, 1'b0, 8'd0, st.to_flag);
            end
            CMD_STOP:  nxt = fin(nxt, 1'b0, 8'd0, st.to_flag);
            CMD_WRITE: nxt = fin(nxt, st.saved_ack, 8'd0, 1'b0);
            CMD_READ:  nxt = fin(nxt, 1'b0, st.shift_reg, 1'b0);
            default:   nxt = fin(nxt, 1'b0, 8'd0, 1'b0);
          endcase
        end
      end
      default: begin
        nxt.s.phase = PH_IDLE;
        nxt.s.cmd   = CMD_NONE;
      end
    endcase
  end

  assign st_next = nxt.s;
  assign res     = nxt.r;

endmodule

[rtl/i2c_bit_level_master.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_bit_level_master
// Open-drain I2C bit-level master, one bus tick per input word.
// ---------------------------------------------------------------------------
// Usage:
//   s_* : one word per bus tick, sampled SCL/SDA levels plus an optional
//         command in s_tuser (none, start, stop, write byte, read byte).
//   m_* : one word per input word: line drives, busy, done pulse and the
//         finish result (ack, received byte, timeout).
//   cfg_*: register writes (phase delay, stretch limit), taken every cycle;
//         write only while the block is idle.
// Throughput is one word per cycle while m_* is not stalled; the next state
// is worked out combinationally by the step logic between the input and
// result registers, which every word from s_* to m_* passes in that order.
// A stall on m_tready holds the result register and then the input
// register; s_tready drops only when both are full. Nothing is lost.
// Reset clears the sequencer to idle with both lines released and restores
// the register defaults (phase delay 16, stretch limit 255).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_bit_level_master import i2cbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,  // tx_byte[7:0], ack_to_send, scl_in, sda_in, pad
  input  logic [2:0]             s_tuser,  // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,  // scl_pull_low, sda_pull_low, busy_res, done_res,
                                           // ack_seen, rx_byte[7:0], timed_out, pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [15:0] phase_delay;
  logic [15:0] stretch_limit;

  logic        in_valid;
  logic [2:0]  in_kind;
  logic [10:0] in_data;
  logic        out_free;

  state_t st;
  state_t st_next;
  res_t   res;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_delay   <= PHASE_DELAY_RST;
      stretch_limit <= STRETCH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PHASE_DELAY) phase_delay <= cfg_data;
      if (cfg_index == REG_STRETCH_LIMIT) stretch_limit <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (out_free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_data <= s_tdata[10:0];
    end
  end

  i2cbm_step u_step (
    .st            (st),
    .phase_delay   (phase_delay),
    .stretch_limit (stretch_limit),
    .kind          (in_kind),
    .tx_byte       (in_data[7:0]),
    .ack_to_send   (in_data[8]),
    .scl_in        (in_data[9]),
    .sda_in        (in_data[10]),
    .st_next       (st_next),
    .res           (res)
  );

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      m_tvalid <= 1'b0;
    end else if (in_valid && out_free) begin
      st       <= st_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && out_free) begin
      m_tdata <= {2'b00, res.to, res.rx, res.ack, res.done,
                  (st_next.phase != PH_IDLE), st_next.sda_drive, st_next.scl_drive};
    end
  end

  `ASSERT_ALWAYS(a_idle_no_cmd, clk, rst, (st.phase != PH_IDLE) || (st.cmd == CMD_NONE), "idle with a command latched")
  `ASSERT_ALWAYS(a_bit_count, clk, rst, st.bit_count <= NBITS, "bit count beyond eight")
  `ASSERT_PROP(a_done_not_busy, clk, rst, (m_tvalid && m_tdata[3]) |-> !m_tdata[2], "done word still busy")
  `ASSERT_PROP(a_in_hold, clk, rst, (in_valid && !out_free) |=> (in_valid && $stable(in_data) && $stable(in_kind)), "input register lost a stalled word")
  `ASSERT_PROP(a_state_hold, clk, rst, !(in_valid && out_free) |=> $stable(st), "state moved without a word")

endmodule

[tb/i2c_bit_level_master_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_bit_level_master_test
// Self-checking bench for the I2C bit-level master. A tick table exercises
// start, stop, write and read with ack, nack and SCL timeouts, then random
// ticks with SCL held low in runs. The random ticks run under several delay
// and limit settings and idling mixes. Every output word is checked field by
// field against a tick-accurate model of the sequencer or a fixed table word.
// ---------------------------------------------------------------------------
module i2c_bit_level_master_test;
  import i2cbm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  typedef struct packed {
    logic       scl_pull;
    logic       sda_pull;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rx;
    logic       to;
  } line_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic        ack;
    logic        scl;
    logic        sda;
    logic [15:0] reps;
    logic        fixed;
    logic [15:0] fixed_word;
  } tick_row_t;

  localparam int DIR_ROWS     = 25;
  localparam int DIR_FAST_ROW = 8;

  tick_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b1, 16'h0000},
    '{KIND_SPARE_A, 8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b1, 16'h0000},
    '{KIND_SPARE_B, 8'hFF, 1'b1, 1'b0, 1'b0, 16'd1,   1'b1, 16'h0000},
    '{KIND_SPARE_C, 8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b1, 16'h0000},
    '{CMD_START,    8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b1, 16'h0004},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b1, 16'd60,  1'b0, 16'h0000},
    '{CMD_STOP,     8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b1, 16'd60,  1'b0, 16'h0000},
    '{CMD_WRITE,    8'hFF, 1'b0, 1'b1, 1'b0, 16'd1,   1'b0, 16'h0000},
    '{CMD_START,    8'h00, 1'b0, 1'b1, 1'b0, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b0, 16'd60,  1'b0, 16'h0000},
    '{CMD_WRITE,    8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b1, 16'd60,  1'b0, 16'h0000},
    '{CMD_READ,     8'h00, 1'b0, 1'b1, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b1, 16'd60,  1'b0, 16'h0000},
    '{CMD_READ,     8'h00, 1'b1, 1'b1, 1'b0, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b1, 1'b0, 16'd60,  1'b0, 16'h0000},
    '{CMD_WRITE,    8'hA5, 1'b0, 1'b0, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b0, 1'b1, 16'd30,  1'b0, 16'h0000},
    '{CMD_READ,     8'h00, 1'b0, 1'b0, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b0, 1'b1, 16'd30,  1'b0, 16'h0000},
    '{CMD_START,    8'h00, 1'b0, 1'b0, 1'b1, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b0, 1'b1, 16'd30,  1'b0, 16'h0000},
    '{CMD_STOP,     8'h00, 1'b0, 1'b0, 1'b0, 16'd1,   1'b0, 16'h0000},
    '{CMD_NONE,     8'h00, 1'b0, 1'b0, 1'b0, 16'd30,  1'b0, 16'h0000}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic [2:0]             s_tuser = CMD_NONE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [15:0]            m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PHASE_DELAY;
  logic [15:0]            cfg_data = '0;

  // sequencer model state
  logic [2:0]  bus_phase;
  logic [2:0]  bus_cmd;
  logic [3:0]  bus_bits;
  logic [7:0]  bus_shift;
  logic [15:0] bus_delay;
  logic [15:0] bus_stretch;
  logic        bus_scl;
  logic        bus_sda;
  logic        bus_ack_saved;
  logic        bus_to_flag;
  logic [15:0] cfg_phase_delay;
  logic [15:0] cfg_stretch_limit;
  logic        fin_done;
  logic        fin_ack;
  logic [7:0]  fin_rx;
  logic        fin_to;

  line_word_t line_words_due [$];
  line_word_t mon_got;
  line_word_t mon_want;

  int err_count    = 0;
  int tick_count   = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int scl_low_left = 0;

  i2c_bit_level_master u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic line_word_t unpack_word(input logic [15:0] d);
    line_word_t w;
    w.scl_pull = d[0];
    w.sda_pull = d[1];
    w.busy     = d[2];
    w.done     = d[3];
    w.ack      = d[4];
    w.rx       = d[12:5];
    w.to       = d[13];
    return w;
  endfunction

  task automatic reset_bus_model();
    bus_phase         = PH_IDLE;
    bus_cmd           = CMD_NONE;
    bus_bits          = '0;
    bus_shift         = '0;
    bus_delay         = '0;
    bus_stretch       = '0;
    bus_scl           = 1'b0;
    bus_sda           = 1'b0;
    bus_ack_saved     = 1'b0;
    bus_to_flag       = 1'b0;
    cfg_phase_delay   = PHASE_DELAY_RST;
    cfg_stretch_limit = STRETCH_LIMIT_RST;
  endtask

  function automatic void finish_cmd(input logic ack, input logic [7:0] rx, input logic to);
    bus_phase = PH_IDLE;
    bus_cmd   = CMD_NONE;
    fin_done  = 1'b1;
    fin_ack   = ack;
    fin_rx    = rx;
    fin_to    = to;
  endfunction

  function automatic void go_pre();
    bus_phase = PH_PRE;
    bus_delay = '0;
  endfunction

  function automatic void go_hold();
    bus_phase = PH_HOLD;
    bus_delay = '0;
  endfunction

  // action at the end of a clock-high phase
  function automatic void clock_high_done(input logic sda);
    case (bus_cmd)
      CMD_START: begin
        bus_sda = 1'b1;
        go_hold();
      end
      CMD_STOP: begin
        bus_sda = 1'b0;
        go_hold();
      end
      CMD_WRITE: begin
        bus_scl = 1'b1;
        if (bus_bits < NBITS) begin
          bus_shift = bus_shift << 1;
          bus_bits  = bus_bits + 4'd1;
          bus_sda   = (bus_bits < NBITS) ? ~bus_shift[MSB_POS] : 1'b0;
          go_pre();
        end else begin
          bus_ack_saved = sda;
          go_hold();
        end
      end
      CMD_READ: begin
        bus_scl = 1'b1;
        if (bus_bits < NBITS) begin
          bus_shift = {bus_shift[6:0], sda};
          bus_bits  = bus_bits + 4'd1;
          if (bus_bits >= NBITS) bus_sda = ~bus_ack_saved;
          go_pre();
        end else begin
          go_hold();
        end
      end
      default: finish_cmd(1'b0, 8'h00, 1'b0);
    endcase
  endfunction

  function automatic line_word_t step_bus(input logic [2:0] kind, input logic [7:0] tx,
                                          input logic ackin, input logic scl,
                                          input logic sda);
    line_word_t w;
    fin_done = 1'b0;
    fin_ack  = 1'b0;
    fin_rx   = 8'h00;
    fin_to   = 1'b0;
    case (bus_phase)
      PH_IDLE: begin
        if (kind >= CMD_START && kind <= CMD_READ) begin
          bus_cmd     = kind;
          bus_to_flag = 1'b0;
          bus_bits    = '0;
          bus_stretch = '0;
          case (kind)
            CMD_START: bus_sda = 1'b0;
            CMD_STOP:  bus_sda = 1'b1;
            CMD_WRITE: begin
              bus_shift = tx;
              bus_sda   = ~tx[MSB_POS];
            end
            default: begin
              bus_shift     = '0;
              bus_ack_saved = ackin;
              bus_sda       = 1'b0;
            end
          endcase
          go_pre();
        end
      end
      PH_PRE: begin
        if (bus_delay != COUNT_MAX) bus_delay = bus_delay + 16'd1;
        if (bus_delay >= cfg_phase_delay) begin
          bus_scl     = 1'b0;
          bus_stretch = '0;
          bus_phase   = PH_POLL;
        end
      end
      PH_POLL: begin
        if (scl) begin
          bus_phase = PH_POST;
          bus_delay = '0;
        end else begin
          if (bus_stretch != COUNT_MAX) bus_stretch = bus_stretch + 16'd1;
          if (bus_stretch >= cfg_stretch_limit) begin
            if (bus_cmd == CMD_WRITE) begin
              finish_cmd(1'b1, 8'h00, 1'b1);
            end else if (bus_cmd == CMD_READ) begin
              finish_cmd(1'b0, 8'h00, 1'b1);
            end else begin
              bus_to_flag = 1'b1;
              clock_high_done(sda);
            end
          end
        end
      end
      PH_POST: begin
        if (bus_delay != COUNT_MAX) bus_delay = bus_delay + 16'd1;
        if (bus_delay >= cfg_phase_delay) clock_high_done(sda);
      end
      PH_HOLD: begin
        if (bus_delay != COUNT_MAX) bus_delay = bus_delay + 16'd1;
        if (bus_delay >= cfg_phase_delay) begin
          case (bus_cmd)
            CMD_START: begin
              bus_scl = 1'b1;
              finish_cmd(1'b0, 8'h00, bus_to_flag);
            end
            CMD_STOP:  finish_cmd(1'b0, 8'h00, bus_to_flag);
            CMD_WRITE: finish_cmd(bus_ack_saved, 8'h00, 1'b0);
            CMD_READ:  finish_cmd(1'b0, bus_shift, 1'b0);
            default:   finish_cmd(1'b0, 8'h00, 1'b0);
          endcase
        end
      end
      default: begin
        bus_phase = PH_IDLE;
        bus_cmd   = CMD_NONE;
      end
    endcase
    w.scl_pull = bus_scl;
    w.sda_pull = bus_sda;
    w.busy     = (bus_phase != PH_IDLE);
    w.done     = fin_done;
    w.ack      = fin_ack;
    w.rx       = fin_rx;
    w.to       = fin_to;
    return w;
  endfunction

  // offer one tick word; returns once it has been taken
  task automatic send_tick(input logic [2:0] kind, input logic [7:0] tx, input logic ack,
                           input logic scl, input logic sda, input logic fixed,
                           input logic [15:0] fixed_word);
    line_word_t want;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, sda, scl, ack, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = step_bus(kind, tx, ack, scl, sda);
    if (fixed) want = unpack_word(fixed_word);
    line_words_due.push_back(want);
  endtask

  task automatic random_tick();
    logic [2:0] kind;
    logic       scl;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 68)      kind = CMD_NONE;
    else if (r < 93) kind = 3'($urandom_range(CMD_START, CMD_READ));
    else             kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
    if (scl_low_left > 0) begin
      scl_low_left--;
      scl = 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      scl_low_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 8);
      scl = 1'b0;
    end else begin
      scl = 1'b1;
    end
    send_tick(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), scl,
              1'($urandom_range(0, 1)), 1'b0, 16'h0000);
  endtask

  task automatic wait_for_results();
    while (line_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] delay_val, input logic [15:0] limit_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PHASE_DELAY;
    cfg_data  <= delay_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_phase_delay = delay_val;
    cfg_index <= REG_STRETCH_LIMIT;
    cfg_data  <= limit_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_stretch_limit = limit_val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] delay_val, input logic [15:0] limit_val,
                           input int gap_pct, input int stall_pct, input int n_ticks,
                           input bit squeeze);
    int i;
    write_regs(delay_val, limit_val);
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    for (i = 0; i < n_ticks; i++) begin
      if (squeeze && i == n_ticks / 3) rx_hold_req = 300;
      if (squeeze && i == (2 * n_ticks) / 3) begin
        s_tvalid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge clk);
      end
      random_tick();
    end
    s_tvalid <= 1'b0;
    wait_for_results();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got = unpack_word(m_tdata);
      if (line_words_due.size() == 0) begin
        $error("unexpected word: %h", m_tdata);
        err_count++;
      end else begin
        mon_want = line_words_due.pop_front();
        check_field("scl_pull_low", mon_want.scl_pull, mon_got.scl_pull);
        check_field("sda_pull_low", mon_want.sda_pull, mon_got.sda_pull);
        check_field("busy_res", mon_want.busy, mon_got.busy);
        check_field("done_res", mon_want.done, mon_got.done);
        check_field("ack_seen", mon_want.ack, mon_got.ack);
        check_field("rx_byte", mon_want.rx, mon_got.rx);
        check_field("timed_out", mon_want.to, mon_got.to);
      end
    end
  end

  always @(posedge clk) begin
    tick_count++;
    if (tick_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int r;
    int k;
    int mode;
    reset_bus_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      // short delays for the byte and timeout rows
      if (r == DIR_FAST_ROW) begin
        s_tvalid <= 1'b0;
        wait_for_results();
        write_regs(16'd2, 16'd20);
      end
      for (k = 0; k < dir_rows[r].reps; k++) begin
        send_tick(dir_rows[r].kind, dir_rows[r].tx, dir_rows[r].ack, dir_rows[r].scl,
                  dir_rows[r].sda, dir_rows[r].fixed && (k == 0), dir_rows[r].fixed_word);
      end
    end
    s_tvalid <= 1'b0;
    wait_for_results();

    run_phase(16'd1,     16'd1,     0,  0,  150, 1'b0);
    run_phase(16'd2,     16'd5,     75, 0,  150, 1'b0);
    run_phase(16'd0,     16'd0,     0,  75, 150, 1'b0);
    run_phase(16'd3,     16'hFFFF,  17, 17, 150, 1'b0);
    run_phase(16'hFFFF,  16'hFFFF,  0,  0,  100, 1'b0);
    run_phase(16'd1,     16'd3,     0,  0,  200, 1'b1);
    for (r = 0; r < 2; r++) begin
      mode = $urandom_range(0, 3);
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 30)),
                (mode == 1) ? 75 : (mode == 3) ? 17 : 0,
                (mode == 2) ? 75 : (mode == 3) ? 17 : 0, 120, 1'b0);
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
